@@ rtl/gf2pr_pkg.sv @@
// Shared types and constants for the GF(2) polynomial residue block.
package gf2pr_pkg;

    localparam int POLY_WIDTH_DEF = 32;
    localparam int WORD_BITS      = 8;
    localparam int RESIDUE_W      = 31;
    localparam int MOD_POLY_W     = 32;
    localparam int MOD_DEG_W      = 5;
    localparam int PDATA_W        = 32;
    localparam int PADDR_W        = 3;

    localparam logic [MOD_POLY_W-1:0] MOD_POLY_RST = MOD_POLY_W'(11);
    localparam logic [MOD_DEG_W-1:0]  MOD_DEG_RST  = MOD_DEG_W'(3);

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_MOD_POLY = 1'b0,
        REG_MOD_DEG  = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [MOD_POLY_W-1:0] mod_poly;
        logic [MOD_DEG_W-1:0]  mod_degree;
    } cfg_t;

endpackage

@@ rtl/gf2pr_step.sv @@
// Combinational update of residue and power term for one data word.
module gf2pr_step #(
    parameter int POLY_WIDTH = gf2pr_pkg::POLY_WIDTH_DEF
) (
    input  gf2pr_pkg::cfg_t                      cfg,
    input  logic [gf2pr_pkg::WORD_BITS-1:0]      data_byte,
    input  logic [POLY_WIDTH-1:0]                residue_in,
    input  logic [POLY_WIDTH-1:0]                power_in,
    output logic [POLY_WIDTH-1:0]                residue_out,
    output logic [POLY_WIDTH-1:0]                power_out
);

    localparam int DW = $clog2(POLY_WIDTH);

    logic [DW-1:0]         deg;
    logic [POLY_WIDTH-1:0] low;
    logic [POLY_WIDTH-1:0] red;

    always_comb begin
        // degree saturates at the top bit of the state
        if (int'(cfg.mod_degree) > POLY_WIDTH - 1) begin
            deg = DW'(POLY_WIDTH - 1);
        end else begin
            deg = DW'(cfg.mod_degree);
        end
        low = (POLY_WIDTH'(1) << deg) - POLY_WIDTH'(1);
        red = POLY_WIDTH'(cfg.mod_poly) & low;
    end

    always_comb begin
        logic [POLY_WIDTH-1:0] res;
        logic [POLY_WIDTH-1:0] pw;
        logic [POLY_WIDTH:0]   shifted;
        res = residue_in & low;
        pw  = power_in & low;
        // x^0 survives the mask unless the modulus is a unit
        if (deg != '0 && power_in == POLY_WIDTH'(1)) begin
            pw = POLY_WIDTH'(1);
        end
        for (int j = 0; j < gf2pr_pkg::WORD_BITS; j++) begin
            if (data_byte[j]) begin
                res = res ^ pw;
            end
            shifted = {pw, 1'b0};
            pw = shifted[POLY_WIDTH-1:0] & low;
            if (shifted[deg]) begin
                pw = pw ^ red;
            end
        end
        residue_out = res;
        power_out   = pw;
    end

endmodule

@@ rtl/gf2_poly_residue_of_byte_stream_top.sv @@
// Top level: byte stream in, GF(2) polynomial residue out, APB register port.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | s_valid s_ready s_data_byte s_last_byte | in
//  result  | m_valid m_ready m_residue               | out
//  config  | psel penable pwrite paddr pwdata ...    | in/out
//
// One word per clock sustained while s_ready is high; a word passes an input
// register, then the eight-bit shift-and-reduce logic, into the state and
// result registers. The residue reaches the result register when the last
// word leaves the input register, with the result register free or emptying.
// Reset (aresetn low, synchronous) clears state to residue 0, power x^0 and
// restores the modulus x^3+x+1. s_ready drops only while a last word waits in
// the input register behind a result that has not been taken.
module gf2_poly_residue_of_byte_stream_top #(
    parameter int POLY_WIDTH = gf2pr_pkg::POLY_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [gf2pr_pkg::WORD_BITS-1:0]     s_data_byte,
    input  logic                                s_last_byte,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [gf2pr_pkg::RESIDUE_W-1:0]     m_residue,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gf2pr_pkg::PADDR_W-1:0]       paddr,
    input  logic [gf2pr_pkg::PDATA_W-1:0]       pwdata,
    output logic [gf2pr_pkg::PDATA_W-1:0]       prdata,
    output logic                                pready
);

    gf2pr_pkg::cfg_t                       cfg_reg;
    gf2pr_pkg::reg_idx_t                   reg_idx;
    logic                                  cfg_write;

    logic                                  in_valid_reg;
    logic [gf2pr_pkg::WORD_BITS-1:0]       in_byte_reg;
    logic                                  in_last_reg;

    logic [POLY_WIDTH-1:0]                 running_residue_reg;
    logic [POLY_WIDTH-1:0]                 power_term_reg;
    logic [POLY_WIDTH-1:0]                 residue_next;
    logic [POLY_WIDTH-1:0]                 power_next;

    logic                                  m_valid_reg;
    logic [gf2pr_pkg::RESIDUE_W-1:0]       m_residue_reg;

    logic                                  step_fire;
    logic                                  s_accept;

    // ---------------- register port ----------------
    assign pready    = 1'b1;
    assign reg_idx   = gf2pr_pkg::reg_idx_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mod_poly   <= gf2pr_pkg::MOD_POLY_RST;
            cfg_reg.mod_degree <= gf2pr_pkg::MOD_DEG_RST;
        end else if (cfg_write) begin
            unique case (reg_idx)
                gf2pr_pkg::REG_MOD_POLY: cfg_reg.mod_poly <= pwdata;
                gf2pr_pkg::REG_MOD_DEG:
                    cfg_reg.mod_degree <= pwdata[gf2pr_pkg::MOD_DEG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            gf2pr_pkg::REG_MOD_POLY: prdata = cfg_reg.mod_poly;
            gf2pr_pkg::REG_MOD_DEG:
                prdata = gf2pr_pkg::PDATA_W'(cfg_reg.mod_degree);
            default: prdata = '0;
        endcase
    end

    // ---------------- data path ----------------
    // a last word needs the result register free (or emptying) to advance
    assign step_fire = in_valid_reg && (!in_last_reg || !m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || step_fire;
    assign s_accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
    end

    gf2pr_step #(
        .POLY_WIDTH (POLY_WIDTH)
    ) u_step (
        .cfg         (cfg_reg),
        .data_byte   (in_byte_reg),
        .residue_in  (running_residue_reg),
        .power_in    (power_term_reg),
        .residue_out (residue_next),
        .power_out   (power_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_residue_reg <= '0;
            power_term_reg      <= POLY_WIDTH'(1);
        end else if (step_fire) begin
            if (in_last_reg) begin
                running_residue_reg <= '0;
                power_term_reg      <= POLY_WIDTH'(1);
            end else begin
                running_residue_reg <= residue_next;
                power_term_reg      <= power_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step_fire && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_fire && in_last_reg) begin
            m_residue_reg <= gf2pr_pkg::RESIDUE_W'(residue_next);
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_residue = m_residue_reg;

    // ---------------- checks ----------------
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_fire && in_last_reg) |=> m_valid_reg)
        else $error("last word did not produce a result");

    a_last_clears_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_fire && in_last_reg) |=>
            (running_residue_reg == '0 && power_term_reg == POLY_WIDTH'(1)))
        else $error("state not cleared after last word");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && in_last_reg && m_valid_reg && !m_ready))
        else $error("input stalled without a blocked result");

endmodule

@@ verif/gf2_poly_residue_of_byte_stream_chk.sv @@
// Checker: watches the byte, residue and register ports, predicts residues and compares.
`timescale 1ns / 100ps

module gf2_poly_residue_of_byte_stream_chk (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [gf2pr_pkg::WORD_BITS-1:0]     s_data_byte,
    input  logic                                s_last_byte,

    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [gf2pr_pkg::RESIDUE_W-1:0]     m_residue,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gf2pr_pkg::PADDR_W-1:0]       paddr,
    input  logic [gf2pr_pkg::PDATA_W-1:0]       pwdata,
    input  logic [gf2pr_pkg::PDATA_W-1:0]       prdata,
    input  logic                                pready,

    output int                                  errors,
    output int                                  outstanding,
    output int                                  residues_checked
);

    typedef logic [gf2pr_pkg::MOD_POLY_W-1:0] poly_t;

    gf2pr_pkg::cfg_t                    cfg;
    poly_t                              acc_residue;
    poly_t                              acc_power;
    logic [gf2pr_pkg::RESIDUE_W-1:0]    expected_residues[$];

    // Fold one word into the residue, LSB first. The 5-bit degree never exceeds
    // 31, so it needs no clamping against the 32-bit state.
    function automatic void fold_byte(input logic [gf2pr_pkg::WORD_BITS-1:0] b,
                                      input gf2pr_pkg::cfg_t c,
                                      input poly_t rem_in, input poly_t pow_in,
                                      output poly_t rem_out, output poly_t pow_out);
        poly_t                           low;
        poly_t                           red;
        poly_t                           rem;
        poly_t                           pw;
        logic [gf2pr_pkg::MOD_POLY_W:0]  sh;
        low = (poly_t'(1) << c.mod_degree) - poly_t'(1);
        red = c.mod_poly & low;
        rem = rem_in & low;
        pw  = pow_in & low;
        // x^0 survives masking unless the modulus is a unit
        if (c.mod_degree != 0 && pow_in == poly_t'(1))
            pw = poly_t'(1);
        for (int j = 0; j < gf2pr_pkg::WORD_BITS; j++) begin
            if (b[j])
                rem ^= pw;
            sh = {pw, 1'b0};
            pw = sh[gf2pr_pkg::MOD_POLY_W-1:0] & low;
            if (sh[c.mod_degree])
                pw ^= red;
        end
        rem_out = rem;
        pow_out = pw;
    endfunction

    always @(posedge aclk) begin : watch
        poly_t                            rem_n;
        poly_t                            pow_n;
        logic [gf2pr_pkg::RESIDUE_W-1:0]  want;
        logic [gf2pr_pkg::PDATA_W-1:0]    reg_val;
        if (!aresetn) begin
            cfg.mod_poly   = gf2pr_pkg::MOD_POLY_RST;
            cfg.mod_degree = gf2pr_pkg::MOD_DEG_RST;
            acc_residue    = '0;
            acc_power      = poly_t'(1);
            expected_residues.delete();
        end else begin
            // pop before queueing: a word taken now cannot produce the residue taken now
            if (m_valid && m_ready) begin
                if (expected_residues.size() == 0) begin
                    errors++;
                    $display("%0t: residue out of turn: expected none, actual %h",
                             $time, m_residue);
                end else begin
                    want = expected_residues.pop_front();
                    residues_checked++;
                    if (m_residue !== want) begin
                        errors++;
                        $display("%0t: residue mismatch: expected %h, actual %h",
                                 $time, want, m_residue);
                    end
                end
            end
            if (s_valid && s_ready) begin
                fold_byte(s_data_byte, cfg, acc_residue, acc_power, rem_n, pow_n);
                if (s_last_byte) begin
                    expected_residues.insert(expected_residues.size(),
                                             rem_n[gf2pr_pkg::RESIDUE_W-1:0]);
                    acc_residue = '0;
                    acc_power   = poly_t'(1);
                end else begin
                    acc_residue = rem_n;
                    acc_power   = pow_n;
                end
            end
            if (psel && penable && pready) begin
                reg_val = (gf2pr_pkg::reg_idx_t'(paddr[2]) == gf2pr_pkg::REG_MOD_DEG)
                        ? gf2pr_pkg::PDATA_W'(cfg.mod_degree) : cfg.mod_poly;
                if (pwrite) begin
                    case (gf2pr_pkg::reg_idx_t'(paddr[2]))
                        gf2pr_pkg::REG_MOD_POLY:
                            cfg.mod_poly = pwdata[gf2pr_pkg::MOD_POLY_W-1:0];
                        gf2pr_pkg::REG_MOD_DEG:
                            cfg.mod_degree = pwdata[gf2pr_pkg::MOD_DEG_W-1:0];
                        default: ;
                    endcase
                end else if (prdata !== reg_val) begin
                    errors++;
                    $display("%0t: register %0d readback: expected %h, actual %h",
                             $time, paddr[2], reg_val, prdata);
                end
            end
        end
        outstanding = expected_residues.size();
    end

endmodule

@@ verif/gf2_poly_residue_of_byte_stream_top_tb.sv @@
// Testbench top: drives byte messages and modulus settings, gives the verdict.
`timescale 1ns / 100ps

module gf2_poly_residue_of_byte_stream_top_tb;

    logic                                aclk        = 1'b0;
    logic                                aresetn     = 1'b0;
    logic                                s_valid     = 1'b0;
    logic                                s_ready;
    logic [gf2pr_pkg::WORD_BITS-1:0]     s_data_byte = '0;
    logic                                s_last_byte = 1'b0;
    logic                                m_valid;
    logic                                m_ready     = 1'b0;
    logic [gf2pr_pkg::RESIDUE_W-1:0]     m_residue;
    logic                                psel        = 1'b0;
    logic                                penable     = 1'b0;
    logic                                pwrite      = 1'b0;
    logic [gf2pr_pkg::PADDR_W-1:0]       paddr       = '0;
    logic [gf2pr_pkg::PDATA_W-1:0]       pwdata      = '0;
    logic [gf2pr_pkg::PDATA_W-1:0]       prdata;
    logic                                pready;

    int errors;
    int outstanding;
    int residues_checked;

    int tx_mode;        // 0: back to back, 1: random gaps, 2: rare gaps
    int rx_mode;
    int rx_stall;
    int words_sent;
    int messages_sent;
    int settings_used;
    int msg_left;       // words still to go in the open message, 0 when none open

    always #5 aclk = ~aclk;

    gf2_poly_residue_of_byte_stream_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_residue   (m_residue),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    gf2_poly_residue_of_byte_stream_chk u_chk (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_last_byte      (s_last_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_residue        (m_residue),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .errors           (errors),
        .outstanding      (outstanding),
        .residues_checked (residues_checked)
    );

    function automatic int draw_gap(input int mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, 11);
            default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 11) : 0;
        endcase
    endfunction

    // result side: stall count drawn per residue taken
    always @(posedge aclk) begin : rx_side
        int n;
        if (!aresetn) begin
            m_ready  <= 1'b0;
            rx_stall <= 0;
        end else if (m_valid && m_ready) begin
            n = draw_gap(rx_mode);
            rx_stall <= n;
            m_ready  <= (n == 0);
        end else if (rx_stall != 0) begin
            rx_stall <= rx_stall - 1;
            m_ready  <= (rx_stall == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_word(input logic [gf2pr_pkg::WORD_BITS-1:0] b, input logic last);
        int gap;
        gap = draw_gap(tx_mode);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        if (last)
            messages_sent++;
    endtask

    // drain all residues, then give the two-stage pipe time to empty
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_xfer(input logic wr, input gf2pr_pkg::reg_idx_t idx,
                            input logic [gf2pr_pkg::PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        if (wr)
            pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_modulus(input logic [gf2pr_pkg::MOD_POLY_W-1:0] poly,
                               input logic [gf2pr_pkg::MOD_DEG_W-1:0] deg);
        logic [gf2pr_pkg::PDATA_W-1:0] deg_word;
        deg_word = $urandom();
        deg_word[gf2pr_pkg::MOD_DEG_W-1:0] = deg;
        apb_xfer(1'b1, gf2pr_pkg::REG_MOD_POLY, poly);
        apb_xfer(1'b1, gf2pr_pkg::REG_MOD_DEG, deg_word);
        apb_xfer(1'b0, gf2pr_pkg::REG_MOD_POLY, '0);
        apb_xfer(1'b0, gf2pr_pkg::REG_MOD_DEG, '0);
        settings_used++;
    endtask

    task automatic run_phase();
        logic [gf2pr_pkg::MOD_POLY_W-1:0] poly;
        logic [gf2pr_pkg::MOD_DEG_W-1:0]  deg;
        logic [gf2pr_pkg::WORD_BITS-1:0]  b;
        logic                             open_end;
        int                               n;
        case ($urandom_range(0, 5))
            0: begin
                deg  = 5'd31;
                poly = $urandom();
            end
            1: begin
                deg  = 5'd0;
                poly = $urandom();
            end
            2: begin
                deg  = 5'd1;
                poly = $urandom_range(0, 1) ? 32'h3 : $urandom();
            end
            default: begin
                deg  = gf2pr_pkg::MOD_DEG_W'($urandom_range(2, 30));
                poly = ($urandom() & ((32'd1 << deg) - 32'd1)) | (32'd1 << deg);
                // junk above the top coefficient must be ignored
                if ($urandom_range(0, 3) == 0)
                    poly |= $urandom() & ~((32'd2 << deg) - 32'd1);
            end
        endcase
        settle();
        set_modulus(poly, deg);
        tx_mode  = $urandom_range(0, 2);
        rx_mode  = $urandom_range(0, 2);
        n        = $urandom_range(40, 160);
        open_end = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < n; k++) begin
            if (msg_left == 0)
                msg_left = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                       : $urandom_range(1, 12);
            if (k == n - 1 && !open_end)
                msg_left = 1;
            if ($urandom_range(0, 7) == 0)
                b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else
                b = gf2pr_pkg::WORD_BITS'($urandom_range(0, 255));
            send_word(b, msg_left == 1);
            msg_left--;
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset modulus x^3+x+1
        tx_mode = 0;
        rx_mode = 0;
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b1);
        send_word(8'h01, 1'b1);
        send_word(8'h80, 1'b1);
        send_word(8'hA5, 1'b0);
        send_word(8'h3C, 1'b0);
        send_word(8'hFF, 1'b1);

        // widest degree, all-ones modulus
        settle();
        set_modulus(32'hFFFF_FFFF, 5'd31);
        tx_mode = 1;
        rx_mode = 1;
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b1);
        send_word(8'h00, 1'b0);
        send_word(8'h80, 1'b1);

        // unit modulus: residue is always zero
        settle();
        set_modulus(32'hFFFF_FFFF, 5'd0);
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b1);

        // degree one, zero low part; leave the second message open
        settle();
        set_modulus(32'h0, 5'd1);
        send_word(8'hFF, 1'b1);
        send_word(8'h81, 1'b0);

        // change modulus mid-message, with junk above the degree
        settle();
        set_modulus(32'hFFFF_011D, 5'd8);
        tx_mode = 2;
        rx_mode = 2;
        send_word(8'h5A, 1'b1);

        msg_left = 0;
        while (words_sent < 1550)
            run_phase();

        settle();
        repeat (8) @(posedge aclk);
        $display("Run covered %0d words in %0d closed messages under %0d modulus settings,",
                 words_sent, messages_sent, settings_used);
        $display("with %0d residues compared against the prediction.", residues_checked);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Timeout with %0d residues still expected", outstanding);
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/gf2pr_pkg.sv
rtl/gf2pr_step.sv
rtl/gf2_poly_residue_of_byte_stream_top.sv
verif/gf2_poly_residue_of_byte_stream_chk.sv
verif/gf2_poly_residue_of_byte_stream_top_tb.sv
